[hdl/sfh_pkg.sv]
`default_nettype none
package sfh_pkg;

	localparam int DEF_SYMBOL_COUNT = 256;
	localparam int DEF_COUNT_BITS   = 16;
	localparam int SYMBOL_W         = 8;
	localparam int OUT_COUNT_W      = 16;

	localparam logic CMD_COUNT = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	typedef struct packed {
		logic count_start;
		logic count_write;
		logic drain_start;
		logic drain_lookup;
		logic out_load;
	} sfh_cmd_t;

	typedef struct packed {
		logic count_hit;
	} sfh_status_t;

endpackage
`default_nettype wire

[hdl/sfh_req_if.sv]
`default_nettype none
interface sfh_req_if
	import sfh_pkg::*;
;
	logic                valid;
	logic                ready;
	logic                command;
	logic [SYMBOL_W-1:0] symbol;

	modport source (output valid, output command, output symbol, input ready);
	modport sink (input valid, input command, input symbol, output ready);
endinterface
`default_nettype wire

[hdl/sfh_res_if.sv]
`default_nettype none
interface sfh_res_if
	import sfh_pkg::*;
;
	logic                   valid;
	logic                   ready;
	logic [SYMBOL_W-1:0]    out_symbol;
	logic [OUT_COUNT_W-1:0] out_count;
	logic                   final_res;
	logic                   empty_res;

	modport source (output valid, output out_symbol, output out_count, output final_res,
		output empty_res, input ready);
	modport sink (input valid, input out_symbol, input out_count, input final_res,
		input empty_res, output ready);
endinterface
`default_nettype wire

[hdl/sfh_ctrl.sv]
`default_nettype none
module sfh_ctrl
	import sfh_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	input  wire logic  in_command,
	output logic       in_ready,
	output logic       out_valid,
	input  wire logic  out_ready,
	input  wire sfh_status_t status,
	output sfh_cmd_t   cmd
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CINC = 2'd1;
	localparam logic [1:0] ST_DRD  = 2'd2;
	localparam logic [1:0] ST_DOUT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_command == CMD_DRAIN) begin
						cmd.drain_start = 1'b1;
						state_nxt       = ST_DRD;
					end else begin
						cmd.count_start = 1'b1;
						if (status.count_hit) begin
							state_nxt = ST_CINC;
						end
					end
				end
			end
			ST_CINC: begin
				cmd.count_write = 1'b1;
				state_nxt       = ST_IDLE;
			end
			ST_DRD: begin
				cmd.drain_lookup = 1'b1;
				state_nxt        = ST_DOUT;
			end
			ST_DOUT: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

[hdl/sfh_dp.sv]
`default_nettype none
module sfh_dp
	import sfh_pkg::*;
#(
	parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT,
	parameter int COUNT_BITS   = DEF_COUNT_BITS
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [SYMBOL_W-1:0] in_symbol,
	input  wire sfh_cmd_t            cmd,
	output sfh_status_t              status,
	output logic [SYMBOL_W-1:0]      out_symbol,
	output logic [OUT_COUNT_W-1:0]   out_count,
	output logic                     final_res,
	output logic                     empty_res
);
	localparam int IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int TOT_W = $clog2(SYMBOL_COUNT + 1);
	localparam logic [SYMBOL_W:0] SYM_LIMIT = (SYMBOL_W + 1)'(SYMBOL_COUNT);
	localparam logic [TOT_W-1:0]  TOT_LIMIT = TOT_W'(SYMBOL_COUNT);

	logic [SYMBOL_COUNT-1:0] seen_q;
	logic [COUNT_BITS-1:0]   count_mem [SYMBOL_COUNT];
	logic [SYMBOL_W-1:0]     order_mem [SYMBOL_COUNT];
	logic [TOT_W-1:0]        distinct_q;
	logic [TOT_W-1:0]        ptr_q;
	logic [IDX_W-1:0]        sym_q;
	logic [COUNT_BITS-1:0]   count_rd_q;
	logic [SYMBOL_W-1:0]     order_rd_q;

	logic [IDX_W-1:0]      sym_idx;
	logic                  sym_ok;
	logic                  first_seen;
	logic                  count_we;
	logic [IDX_W-1:0]      count_waddr;
	logic [COUNT_BITS-1:0] count_wdata;
	logic                  count_re;
	logic [IDX_W-1:0]      count_raddr;
	logic [COUNT_BITS-1:0] count_inc;
	logic [OUT_COUNT_W-1:0] count_sat;
	logic                  is_empty;
	logic                  is_last;
	logic [TOT_W:0]        ptr_next;

	assign sym_idx   = in_symbol[IDX_W-1:0];
	assign sym_ok    = (in_symbol != '0) && ({1'b0, in_symbol} < SYM_LIMIT);
	assign status.count_hit = sym_ok && seen_q[sym_idx];
	assign first_seen = cmd.count_start && sym_ok && !seen_q[sym_idx];

	assign count_inc = (count_rd_q == '1) ? count_rd_q : count_rd_q + 1'b1;

	always_comb begin
		count_we    = first_seen || cmd.count_write;
		count_waddr = cmd.count_write ? sym_q : sym_idx;
		count_wdata = cmd.count_write ? count_inc : COUNT_BITS'(1);
		count_re    = cmd.count_start || cmd.drain_lookup;
		count_raddr = cmd.drain_lookup ? order_rd_q[IDX_W-1:0] : sym_idx;
	end

	generate
		if (COUNT_BITS > OUT_COUNT_W) begin : g_sat
			assign count_sat = (|count_rd_q[COUNT_BITS-1:OUT_COUNT_W]) ? '1
				: count_rd_q[OUT_COUNT_W-1:0];
		end else begin : g_ext
			assign count_sat = OUT_COUNT_W'(count_rd_q);
		end
	endgenerate

	assign is_empty = (distinct_q == '0);
	assign ptr_next = {1'b0, ptr_q} + 1'b1;
	assign is_last  = (ptr_next >= {1'b0, distinct_q});

	always_ff @(posedge clk) begin
		if (count_we) begin
			count_mem[count_waddr] <= count_wdata;
		end
		if (count_re) begin
			count_rd_q <= count_mem[count_raddr];
		end
		if (first_seen && (distinct_q < TOT_LIMIT)) begin
			order_mem[distinct_q[IDX_W-1:0]] <= in_symbol;
		end
		if (cmd.drain_start) begin
			order_rd_q <= order_mem[ptr_q[IDX_W-1:0]];
		end
		if (cmd.count_start) begin
			sym_q <= sym_idx;
		end
		if (cmd.out_load) begin
			if (is_empty) begin
				out_symbol <= '0;
				out_count  <= '0;
				final_res  <= 1'b0;
				empty_res  <= 1'b1;
			end else begin
				out_symbol <= order_rd_q;
				out_count  <= count_sat;
				final_res  <= is_last;
				empty_res  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= '0;
			distinct_q <= '0;
			ptr_q      <= '0;
		end else begin
			if (first_seen) begin
				seen_q[sym_idx] <= 1'b1;
				if (distinct_q < TOT_LIMIT) begin
					distinct_q <= distinct_q + 1'b1;
				end
			end
			if (cmd.out_load && !is_empty) begin
				if (is_last) begin
					seen_q     <= '0;
					distinct_q <= '0;
					ptr_q      <= '0;
				end else begin
					ptr_q <= ptr_next[TOT_W-1:0];
				end
			end
		end
	end
endmodule
`default_nettype wire

[hdl/symbol_frequency_histogram.sv]
// Byte frequency histogram.
// req channel: command (count or drain) and symbol. res channel: one result
// per drain request (out_symbol, out_count, final_res, empty_res); counts
// produce no result.
// A count request for a first-seen or ignored symbol (zero or out of range)
// is handled in the idle state alone; for a repeat symbol the counter memory
// is read there, then written back with the saturated increment in a write state.
// A drain request reads the order list, then the counter, then loads the
// result into an output register; req is taken again while it waits. A
// further drain stalls in its load step until res frees.
// Requests are handled one at a time.
// Reset clears the seen flags, distinct total and drain pointer and drops any
// pending result; counter and order memories need no clearing. After the
// final entry is drained the same message state is cleared with that load.
// A drain with nothing counted returns empty_res with all other fields zero.
`default_nettype none
module symbol_frequency_histogram
	import sfh_pkg::*;
#(
	parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT,
	parameter int COUNT_BITS   = DEF_COUNT_BITS
) (
	input wire logic   clk,
	input wire logic   arst_n,
	sfh_req_if.sink    req,
	sfh_res_if.source  res
);
	sfh_cmd_t    cmd;
	sfh_status_t status;

	sfh_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (req.valid),
		.in_command (req.command),
		.in_ready   (req.ready),
		.out_valid  (res.valid),
		.out_ready  (res.ready),
		.status     (status),
		.cmd        (cmd)
	);

	sfh_dp #(
		.SYMBOL_COUNT (SYMBOL_COUNT),
		.COUNT_BITS   (COUNT_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_symbol  (req.symbol),
		.cmd        (cmd),
		.status     (status),
		.out_symbol (res.out_symbol),
		.out_count  (res.out_count),
		.final_res  (res.final_res),
		.empty_res  (res.empty_res)
	);
endmodule
`default_nettype wire
